/* design/ppu_pkg.sv */
// Shared constants, state encoding and fixed-point helpers for the particle pool.
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

   // Pool geometry
   localparam int POOL_SIZE = 64;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int CNT_W     = IDX_W + 1;
   localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);

   // Field widths
   localparam int SLOT_W = 6;
   localparam int DATA_W = 32;
   localparam int DT_W   = 17;
   localparam int JIT_W  = 7;
   localparam int PICK_W = 2;
   localparam int JT_W   = 20;
   localparam int FRAC_W = 16;

   // Fixed-point constants
   localparam logic [FRAC_W-1:0] LIFE_FRACTION = 16'hC000;   // 0.75
   localparam logic [12:0]       TENTH_Q16     = 13'd6553;   // floor(65536 / 10)
   localparam logic [3:0]        TENTH_REM     = 4'd6;       // 65536 mod 10
   localparam logic [3:0]        ROUND_HALF    = 4'd5;
   localparam logic [7:0]        RECIP10       = 8'd205;     // 205 / 2048 ~ 1/10
   localparam int                RECIP10_SHIFT = 11;

   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   // Command codes
   localparam logic CMD_SPAWN = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_TICK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Jitter in tenths to Q16.16, rounded to nearest, sign kept.
   // (mag * 65536 + 5) / 10 = mag * 6553 + (mag * 6 + 5) / 10
   function automatic logic signed [JT_W-1:0] jitter_term(input logic signed [JIT_W-1:0] jit);
      logic [JIT_W-1:0] mag;
      logic [JT_W-1:0]  base;
      logic [9:0]       rnd;
      logic [17:0]      scaled;
      logic [JT_W-1:0]  q;
      mag    = jit[JIT_W-1] ? JIT_W'(-jit) : JIT_W'(jit);
      base   = JT_W'(mag) * JT_W'(TENTH_Q16);
      rnd    = 10'(mag) * 10'(TENTH_REM) + 10'(ROUND_HALF);
      scaled = 18'(rnd) * 18'(RECIP10);
      q      = base + JT_W'(scaled >> RECIP10_SHIFT);
      return jit[JIT_W-1] ? -$signed(q) : $signed(q);
   endfunction

   // Signed add of a jitter term with saturation at both ends.
   function automatic logic signed [DATA_W-1:0] sat_add_jt(
      input logic signed [DATA_W-1:0] base,
      input logic signed [JT_W-1:0]   jt
   );
      logic signed [DATA_W:0] sum;
      sum = $signed({base[DATA_W-1], base})
          + $signed({{(DATA_W+1-JT_W){jt[JT_W-1]}}, jt});
      if (sum[DATA_W] != sum[DATA_W-1]) begin
         return sum[DATA_W] ? DATA_MIN : DATA_MAX;
      end
      return sum[DATA_W-1:0];
   endfunction

   // Subtract a non-negative amount, saturating at the signed minimum.
   function automatic logic signed [DATA_W-1:0] sat_sub_min(
      input logic signed [DATA_W-1:0] base,
      input logic [DATA_W-1:0]        amount
   );
      logic signed [DATA_W:0] diff;
      diff = $signed({base[DATA_W-1], base}) - $signed({1'b0, amount});
      if (diff[DATA_W] != diff[DATA_W-1]) begin
         return DATA_MIN;
      end
      return diff[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/particle_pool_update.sv */
// Particle pool: round-robin free-slot spawn and per-tick life and height update.
`timescale 1ns / 1ps
`default_nettype none

// The pool holds POOL_SIZE particles (life, x, y, z in signed Q16.16) in on-chip
// memories cleared at reset through per-slot valid flags, so no clearing pass is needed.
// One item is worked at a time: req_stall stays high from the transfer until the result
// has been loaded into the output register. Both commands walk the pool through the
// single read port of the life/y memories, one slot per cycle, with one compare or
// saturating-subtract stage behind the read. A spawn ends its walk at the first free
// slot from the search start; a spawn into a full pool and a tick walk all POOL_SIZE
// slots. A new item can be taken while a finished result still waits on rsp_stall.
module particle_pool_update (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_cmd,
   input  wire         [ppu_pkg::DT_W-1:0]       req_step_time,
   input  wire  signed [ppu_pkg::DATA_W-1:0]     req_offset_x,
   input  wire  signed [ppu_pkg::DATA_W-1:0]     req_offset_y,
   input  wire  signed [ppu_pkg::DATA_W-1:0]     req_offset_z,
   input  wire  signed [ppu_pkg::JIT_W-1:0]      req_jitter_x,
   input  wire  signed [ppu_pkg::JIT_W-1:0]      req_jitter_y,
   input  wire  signed [ppu_pkg::JIT_W-1:0]      req_jitter_z,
   input  wire         [ppu_pkg::PICK_W-1:0]     req_life_pick,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_found,
   output logic        [ppu_pkg::SLOT_W-1:0]     rsp_slot
);
   import ppu_pkg::*;

   // Sequencer state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic              pv_ff, pv_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic              res_found_ff, res_found_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // Latched item
   logic        [DT_W-1:0]   dt_ff;
   logic signed [DATA_W-1:0] off_x_ff, off_y_ff, off_z_ff;
   logic signed [JT_W-1:0]   jt_x_ff, jt_y_ff, jt_z_ff;
   logic        [PICK_W-1:0] pick_ff;

   // Pool storage
   logic signed [DATA_W-1:0] life_mem [POOL_SIZE];
   logic signed [DATA_W-1:0] posx_mem [POOL_SIZE];
   logic signed [DATA_W-1:0] posy_mem [POOL_SIZE];
   logic signed [DATA_W-1:0] posz_mem [POOL_SIZE];
   logic [POOL_SIZE-1:0]     vld_ff;
   logic signed [DATA_W-1:0] life_rd_ff, posy_rd_ff;
   logic                     vld_rd_ff;

   logic                     req_accept;
   logic                     walking;
   logic                     issue;
   logic                     hit;
   logic                     tick_wr;
   logic                     wr_en;
   logic                     walk_done;
   logic                     rsp_load;
   logic [CNT_W-1:0]         wrap_sum;
   logic [CNT_W-1:0]         wrap_idx;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] life_eff, posy_eff;
   logic                     life_free;
   logic signed [DATA_W-1:0] life_wr, posy_wr;
   logic signed [DATA_W-1:0] spawn_x, spawn_y, spawn_z;
   logic [SLOT_W+IDX_W-1:0]  slot_wide;

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Slot of the entry in the check stage (low bits only)
   assign slot_wide = {{SLOT_W{1'b0}}, pidx_ff};

   // Effective read data: a slot never written reads as zero
   assign life_eff  = vld_rd_ff ? life_rd_ff : '0;
   assign posy_eff  = vld_rd_ff ? posy_rd_ff : '0;
   assign life_free = life_eff[DATA_W-1] || (life_eff == '0);

   // Walk control
   assign walking   = (state_ff == ST_SEARCH) || (state_ff == ST_TICK);
   assign hit       = (state_ff == ST_SEARCH) && pv_ff && life_free;
   assign tick_wr   = (state_ff == ST_TICK) && pv_ff;
   assign wr_en     = hit || tick_wr;
   assign issue     = walking && (cnt_ff != POOL_CNT) && !hit;
   assign walk_done = (cnt_ff == POOL_CNT) && !pv_ff;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Round-robin address from the search start for a spawn; a tick walks from slot zero
   assign wrap_sum = {1'b0, start_ff} + cnt_ff;
   assign wrap_idx = (wrap_sum >= POOL_CNT) ? wrap_sum - POOL_CNT : wrap_sum;
   assign rd_addr  = (state_ff == ST_TICK) ? cnt_ff[IDX_W-1:0] : wrap_idx[IDX_W-1:0];

   // Spawn values and tick updates
   assign spawn_x = sat_add_jt(off_x_ff, jt_x_ff);
   assign spawn_y = sat_add_jt(off_y_ff, jt_y_ff);
   assign spawn_z = sat_add_jt(off_z_ff, jt_z_ff);
   assign life_wr = hit ? $signed(DATA_W'({pick_ff, LIFE_FRACTION}))
                        : sat_sub_min(life_eff, DATA_W'(dt_ff));
   assign posy_wr = hit ? spawn_y : sat_sub_min(posy_eff, DATA_W'(dt_ff >> 1));

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = issue ? cnt_ff + 1'b1 : cnt_ff;
      start_in     = start_ff;
      pv_in        = issue;
      pidx_in      = rd_addr;
      res_found_in = res_found_ff;
      res_slot_in  = res_slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cnt_in   = '0;
               state_in = (req_cmd == CMD_TICK) ? ST_TICK : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               start_in     = pidx_ff;
               res_found_in = 1'b1;
               res_slot_in  = slot_wide[SLOT_W-1:0];
               state_in     = ST_FINISH;
            end else if (walk_done) begin
               res_found_in = 1'b0;
               res_slot_in  = '0;
               state_in     = ST_FINISH;
            end
         end
         ST_TICK: begin
            if (walk_done) begin
               res_found_in = 1'b0;
               res_slot_in  = '0;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a finished result, drop it once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_slot_in  = res_slot_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         start_ff     <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      res_found_ff <= res_found_in;
      res_slot_ff  <= res_slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   // Hold the item for the whole walk
   always_ff @(posedge clock) begin
      if (req_accept) begin
         dt_ff    <= req_step_time;
         off_x_ff <= req_offset_x;
         off_y_ff <= req_offset_y;
         off_z_ff <= req_offset_z;
         jt_x_ff  <= jitter_term(req_jitter_x);
         jt_y_ff  <= jitter_term(req_jitter_y);
         jt_z_ff  <= jitter_term(req_jitter_z);
         pick_ff  <= req_life_pick;
      end
   end

   // Slot valid flags: cleared at reset, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[pidx_ff] <= 1'b1;
      end
   end

   // Life and y memories: one registered read, one write per cycle
   always_ff @(posedge clock) begin
      life_rd_ff <= life_mem[rd_addr];
      posy_rd_ff <= posy_mem[rd_addr];
      vld_rd_ff  <= vld_ff[rd_addr];
      if (wr_en) begin
         life_mem[pidx_ff] <= life_wr;
         posy_mem[pidx_ff] <= posy_wr;
      end
   end

   // x and z memories: written on spawn only
   always_ff @(posedge clock) begin
      if (hit) begin
         posx_mem[pidx_ff] <= spawn_x;
         posz_mem[pidx_ff] <= spawn_z;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_slot  = rsp_slot_ff;

endmodule

`default_nettype wire

/* design/ppu_checker.sv */
// Port-level checks on the particle pool and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module ppu_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire                          rsp_found,
   input wire [ppu_pkg::SLOT_W-1:0]    rsp_slot
);
   import ppu_pkg::*;

   // A miss or a tick reports slot zero
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_slot == '0)
      else $error("result without a hit carries a nonzero slot");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_slot))
      else $error("stalled result changed or dropped");

   // Drop any result on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Stay busy after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous one is still walking the pool");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the particle pool spawn and tick block.
`timescale 1ns / 1ps

module tb_top;
   import ppu_pkg::*;

   // One request as it crosses the req_ channel
   typedef struct {
      logic                       cmd;
      logic        [DT_W-1:0]     step_time;
      logic signed [DATA_W-1:0]   offset_x;
      logic signed [DATA_W-1:0]   offset_y;
      logic signed [DATA_W-1:0]   offset_z;
      logic signed [JIT_W-1:0]    jitter_x;
      logic signed [JIT_W-1:0]    jitter_y;
      logic signed [JIT_W-1:0]    jitter_z;
      logic        [PICK_W-1:0]   life_pick;
   } pool_req_type;

   // What a request reports back: the slot a spawn claimed, if any
   typedef struct {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } spawn_outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_cmd = CMD_SPAWN;
   logic        [DT_W-1:0]     req_step_time = '0;
   logic signed [DATA_W-1:0]   req_offset_x = '0;
   logic signed [DATA_W-1:0]   req_offset_y = '0;
   logic signed [DATA_W-1:0]   req_offset_z = '0;
   logic signed [JIT_W-1:0]    req_jitter_x = '0;
   logic signed [JIT_W-1:0]    req_jitter_y = '0;
   logic signed [JIT_W-1:0]    req_jitter_z = '0;
   logic        [PICK_W-1:0]   req_life_pick = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_found;
   logic        [SLOT_W-1:0]   rsp_slot;

   // Shadow of the pool: remaining life per slot and the round-robin start.
   // Positions never reach the ports, so they are not tracked.
   int          pool_life [POOL_SIZE];
   int unsigned pool_search_start = 0;

   spawn_outcome_type outcome_q[$];

   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned err_count     = 0;
   int unsigned n_items       = 0;
   int unsigned n_spawn       = 0;
   int unsigned n_placed      = 0;
   int unsigned n_pool_full   = 0;
   int unsigned n_tick        = 0;
   int unsigned n_checked     = 0;

   particle_pool_update i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_step_time (req_step_time),
      .req_offset_x  (req_offset_x),
      .req_offset_y  (req_offset_y),
      .req_offset_z  (req_offset_z),
      .req_jitter_x  (req_jitter_x),
      .req_jitter_y  (req_jitter_y),
      .req_jitter_z  (req_jitter_z),
      .req_life_pick (req_life_pick),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_slot      (rsp_slot)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one accepted request to the shadow pool and return its outcome
   function automatic spawn_outcome_type claim_or_age(input pool_req_type it);
      spawn_outcome_type res;
      int unsigned       idx;
      longint            diff;
      res.found = 1'b0;
      res.slot  = '0;
      if (it.cmd == CMD_SPAWN) begin
         n_spawn++;
         // Search from the start pointer to the end, then wrap to zero
         for (int k = 0; k < POOL_SIZE; k++) begin
            idx = (pool_search_start + k) % POOL_SIZE;
            if (pool_life[idx] <= 0) begin
               pool_life[idx]    = (int'(it.life_pick) <<< FRAC_W) + int'(LIFE_FRACTION);
               pool_search_start = idx;
               res.found         = 1'b1;
               res.slot          = SLOT_W'(idx);
               break;
            end
         end
         if (res.found) n_placed++;
         else n_pool_full++;
      end else begin
         n_tick++;
         // Age every slot, saturating at the signed minimum
         for (int k = 0; k < POOL_SIZE; k++) begin
            diff = longint'(pool_life[k]) - longint'(it.step_time);
            pool_life[k] = (diff < longint'(DATA_MIN)) ? int'(DATA_MIN) : int'(diff);
         end
      end
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_coord();
      case ($urandom_range(7))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return DATA_MAX - $urandom_range(500000);
         3:       return DATA_MIN + $urandom_range(500000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] rand_step();
      case ($urandom_range(7))
         0:       return '0;
         1, 2:    return DT_W'($urandom_range(8192));
         3, 4, 5: return DT_W'($urandom_range(65536));
         6:       return DT_W'(65536);
         default: return DT_W'($urandom);
      endcase
   endfunction

   // Random content for a request of the given command
   function automatic pool_req_type rand_item(input logic cmd);
      pool_req_type it;
      it.cmd       = cmd;
      it.step_time = rand_step();
      it.offset_x  = rand_coord();
      it.offset_y  = rand_coord();
      it.offset_z  = rand_coord();
      it.jitter_x  = JIT_W'($urandom_range(127));
      it.jitter_y  = JIT_W'($urandom_range(127));
      it.jitter_z  = JIT_W'($urandom_range(127));
      it.life_pick = PICK_W'($urandom_range(3));
      return it;
   endfunction

   // Drive one request, hold it until transfer, then record its outcome
   task automatic send_item(input pool_req_type it);
      int unsigned gap;
      if ($urandom_range(99) < req_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(80, 8) : $urandom_range(3, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= it.cmd;
      req_step_time <= it.step_time;
      req_offset_x  <= it.offset_x;
      req_offset_y  <= it.offset_y;
      req_offset_z  <= it.offset_z;
      req_jitter_x  <= it.jitter_x;
      req_jitter_y  <= it.jitter_y;
      req_jitter_z  <= it.jitter_z;
      req_life_pick <= it.life_pick;
      do @(posedge clock); while (req_stall);
      outcome_q.insert(outcome_q.size(), claim_or_age(it));
      n_items++;
   endtask

   task automatic spawn_at(
      input logic signed [DATA_W-1:0] ox, input logic signed [DATA_W-1:0] oy,
      input logic signed [DATA_W-1:0] oz, input logic signed [JIT_W-1:0] jx,
      input logic signed [JIT_W-1:0] jy, input logic signed [JIT_W-1:0] jz,
      input logic [PICK_W-1:0] pick
   );
      pool_req_type it;
      it = rand_item(CMD_SPAWN);
      it.offset_x  = ox;
      it.offset_y  = oy;
      it.offset_z  = oz;
      it.jitter_x  = jx;
      it.jitter_y  = jy;
      it.jitter_z  = jz;
      it.life_pick = pick;
      send_item(it);
   endtask

   task automatic tick_by(input logic [DT_W-1:0] dt);
      pool_req_type it;
      it = rand_item(CMD_TICK);
      it.step_time = dt;
      send_item(it);
   endtask

   // Field extremes, extreme pick and jitter, long ticks, life hitting zero exactly
   task automatic test_directed();
      req_idle_pct  = 38;
      rsp_stall_pct = 38;
      spawn_at(DATA_MAX, DATA_MAX, DATA_MAX, 63, 49, 63, 3);
      spawn_at(DATA_MIN, DATA_MIN, DATA_MIN, -64, -50, -64, 0);
      spawn_at(0, 0, 0, 0, 0, 0, 2);
      spawn_at(32'sh7FFF_0000, -1, 32'sh8000_FFFF, 49, -1, 1, 1);
      spawn_at(-32'sd65536, 32'sd65536, 0, -50, 50, -1, 0);
      tick_by('0);
      tick_by(DT_W'(1));
      tick_by(DT_W'(65536));
      spawn_at(1, -1, 0, 5, -5, 0, 2);
      spawn_at(0, 0, 0, -1, 1, 63, 1);
      tick_by(DT_W'(17'h1FFFF));
      tick_by(DT_W'(17'h1FFFF));
      spawn_at(0, 0, 0, 10, 20, 30, 0);
      spawn_at(0, 0, 0, -10, -20, -30, 1);
      spawn_at(0, 0, 0, 1, 2, 3, 2);
      spawn_at(0, 0, 0, -1, -2, -3, 3);
      // A pick of zero lives exactly 0.75 and is free again once that much has passed
      tick_by(DT_W'(49152));
      spawn_at(DATA_MAX, DATA_MIN, 0, -64, 63, 0, 0);
      tick_by(DT_W'(49151));
      spawn_at(0, 0, 0, 0, 0, 0, 0);
      tick_by(DT_W'(17'h10000));
   endtask

   // Fill the whole pool without idling, overflow it, free every slot, then spawn again
   task automatic test_fill_and_overflow();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (POOL_SIZE + 6) send_item(rand_item(CMD_SPAWN));
      tick_by(DT_W'(17'h1FFFF));
      tick_by(DT_W'(17'h1FFFF));
      repeat (5) send_item(rand_item(CMD_SPAWN));
   endtask

   // Spawn bursts with random content, separated by ticks, with some noise mixed in
   task automatic test_spawn_tick_bursts();
      int unsigned stop_at;
      int unsigned burst;
      stop_at       = n_items + 1000;
      req_idle_pct  = 38;
      rsp_stall_pct = 38;
      while (n_items < stop_at) begin
         burst = ($urandom_range(9) == 0) ? $urandom_range(72, 60) : $urandom_range(24, 1);
         repeat (burst) begin
            if ($urandom_range(6) == 0) send_item(rand_item(1'($urandom)));
            else send_item(rand_item(CMD_SPAWN));
         end
         repeat ($urandom_range(3, 1)) send_item(rand_item(CMD_TICK));
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Compare each result transfer with the oldest outcome
   always @(posedge clock) begin : check_results
      spawn_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            $error("result with none outstanding: found %0d slot %0d", rsp_found, rsp_slot);
            err_count++;
         end else begin
            want = outcome_q.pop_front();
            n_checked++;
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               err_count++;
            end
            if (rsp_slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
               err_count++;
            end
         end
      end
   end

   initial begin
      int unsigned waited;
      for (int k = 0; k < POOL_SIZE; k++) pool_life[k] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_overflow();
      test_spawn_tick_bursts();
      req_valid <= 1'b0;
      // Drain the outstanding results, then watch for strays
      rsp_stall_pct = 38;
      waited = 0;
      while (outcome_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (outcome_q.size() != 0) begin
         $error("%0d results never arrived", outcome_q.size());
         err_count++;
      end
      repeat (80) @(posedge clock);
      $display("Covered %0d spawns (%0d placed, %0d into a full pool) and %0d ticks.",
               n_spawn, n_placed, n_pool_full, n_tick);
      $display("Checked %0d results; %0d mismatches.", n_checked, err_count);
      if (err_count == 0) begin
         $display("particle_pool_update verification clean");
      end else begin
         $display("particle_pool_update verification failed");
      end
      $finish;
   end

   // Hard stop in case the block hangs
   initial begin
      #8_000_000;
      $display("Timed out with %0d results outstanding.", outcome_q.size());
      $display("particle_pool_update verification failed");
      $finish;
   end

endmodule

/* sim.f */
design/ppu_pkg.sv
design/particle_pool_update.sv
design/ppu_checker.sv
sim/tb_top.sv
